// File: hw/rtl/rvaa_pkg.sv
// Shared types and constants for the axis rotation block.
// Used by the trigonometry sequencer, the point pipeline and the top level.
package rvaa_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int AXIS_W      = 16;
    localparam int TRIG_W      = 18;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_AXIS_X     = 2'd0,
        CFG_AXIS_Y     = 2'd1,
        CFG_AXIS_Z     = 2'd2,
        CFG_TURN_ANGLE = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } t_axis;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cosine;
        logic signed [TRIG_W-1:0] sine;
    } t_trig;

    localparam t_axis AXIS_RESET = '{x: 16'sd0, y: 16'sd0, z: 16'sd16384};
    localparam t_trig TRIG_RESET = '{cosine: 18'sd65536, sine: 18'sd0};

    // Angle steps are 1/64 degree.
    localparam int STEPS_FULL   = 23040;
    localparam int STEPS_QUAD   = 5760;
    localparam int STEPS_OCT    = 2880;
    localparam int RAD_PER_STEP = 1171271;
    localparam int ONE_Q30      = 1 << 30;
    localparam int HALF_Q14     = 8192;
    localparam int SIN_LAST     = 3;
    localparam int COS_LAST     = 8;

    // Scale of the reciprocals used to divide by the Horner divisors.
    localparam longint RECIP_SCALE = 64'h1_0000_0000;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quadrant;

    typedef enum logic [3:0] {
        TRIG_IDLE,
        TRIG_FOLD,
        TRIG_RAD,
        TRIG_SQR,
        TRIG_MUL,
        TRIG_DIV,
        TRIG_FIX,
        TRIG_SUB,
        TRIG_SINF,
        TRIG_DONE
    } t_trig_state;

    // Divisors of the Horner steps: sine terms first, then cosine terms.
    function automatic logic [6:0] horner_div(input logic [3:0] step);
        logic [6:0] k;
        unique case (step)
            4'd0:    k = 7'd72;
            4'd1:    k = 7'd42;
            4'd2:    k = 7'd20;
            4'd3:    k = 7'd6;
            4'd4:    k = 7'd90;
            4'd5:    k = 7'd56;
            4'd6:    k = 7'd30;
            4'd7:    k = 7'd12;
            default: k = 7'd2;
        endcase
        return k;
    endfunction

    // Reciprocals floor(2^32 / k) of the same divisors, in the same order.
    function automatic logic [31:0] horner_recip(input logic [3:0] step);
        logic [31:0] m;
        unique case (step)
            4'd0:    m = 32'(RECIP_SCALE / 72);
            4'd1:    m = 32'(RECIP_SCALE / 42);
            4'd2:    m = 32'(RECIP_SCALE / 20);
            4'd3:    m = 32'(RECIP_SCALE / 6);
            4'd4:    m = 32'(RECIP_SCALE / 90);
            4'd5:    m = 32'(RECIP_SCALE / 56);
            4'd6:    m = 32'(RECIP_SCALE / 30);
            4'd7:    m = 32'(RECIP_SCALE / 12);
            default: m = 32'(RECIP_SCALE / 2);
        endcase
        return m;
    endfunction

endpackage

// File: hw/rtl/rvaa_point_if.sv
// Input channel of the axis rotation block: one 3-D point per item.
// Stand-alone interface, no package needed.
interface rvaa_point_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

// File: hw/rtl/rvaa_rotated_if.sv
// Output channel of the axis rotation block: one rotated point per item.
// Stand-alone interface, no package needed.
interface rvaa_rotated_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] rotated_x;
    logic signed [COORD_WIDTH-1:0] rotated_y;
    logic signed [COORD_WIDTH-1:0] rotated_z;

    modport source (output valid, output rotated_x, output rotated_y, output rotated_z,
                    input ready);
    modport sink   (input valid, input rotated_x, input rotated_y, input rotated_z,
                    output ready);
endinterface

// File: hw/rtl/rotate_vector_about_axis_unit.sv
// Top level of the axis rotation block: configuration registers and wiring.
// Depends on rvaa_pkg, rvaa_point_if, rvaa_rotated_if, rvaa_trig and rvaa_core.
//
// The block rotates 3-D points (signed Q16.16) about a configured axis by a
// configured angle, using the Rodrigues form. Points arrive as items on the
// valid/ready channel i_point; each gives exactly one rotated, saturated
// point on o_rotated. The axis (Q1.14, used as written) and the angle (1/64
// degree steps, any value wrapped to one turn) are written through the plain
// write port i_cfg_we / i_cfg_index / i_cfg_data, one register per cycle.
// Throughput is one item per cycle while the receiver keeps up and no angle
// update runs; each item passes the seven-stage point pipeline, whose products
// are formed in stages 1, 3 and 5, into the output register. An angle write
// starts the cosine/sine sequencer, which folds the angle, turns it into radians
// and squares it, then runs nine Horner steps, each a multiply, a divide by
// reciprocal multiply, a quotient fix and a subtract; it scales the sine after
// the sine terms and stores the result. i_point.ready stays low while it runs.
// Reset (synchronous, active low) empties the pipeline and sets the axis to
// +z and the angle to zero, with cosine one and sine zero. When the receiver
// stalls, results hold in the output register and earlier stages keep
// filling until every stage is occupied; only then does i_point.ready fall.
module rotate_vector_about_axis_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rvaa_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [rvaa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    rvaa_point_if.sink                       i_point,
    rvaa_rotated_if.source                   o_rotated
);

    rvaa_pkg::t_axis      r_axis;
    rvaa_pkg::t_cfg_index cfg_sel;
    rvaa_pkg::t_trig      trig;
    logic                 angle_wr;
    logic                 trig_busy;

    assign cfg_sel  = rvaa_pkg::t_cfg_index'(i_cfg_index);
    assign angle_wr = i_cfg_we && (cfg_sel == rvaa_pkg::CFG_TURN_ANGLE);

    // Axis components are stored as written; the angle goes straight to the
    // sequencer, which keeps only the cosine and sine it derives.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= rvaa_pkg::AXIS_RESET;
        end else if (i_cfg_we) begin
            unique case (cfg_sel)
                rvaa_pkg::CFG_AXIS_X:     r_axis.x <= i_cfg_data;
                rvaa_pkg::CFG_AXIS_Y:     r_axis.y <= i_cfg_data;
                rvaa_pkg::CFG_AXIS_Z:     r_axis.z <= i_cfg_data;
                rvaa_pkg::CFG_TURN_ANGLE: r_axis   <= r_axis;
            endcase
        end
    end

    rvaa_trig u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (angle_wr),
        .i_angle (i_cfg_data),
        .o_busy  (trig_busy),
        .o_trig  (trig)
    );

    // Items are held off while the sequencer rewrites cosine and sine.
    rvaa_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hold    (trig_busy),
        .i_axis    (r_axis),
        .i_trig    (trig),
        .i_point   (i_point),
        .o_rotated (o_rotated)
    );

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trig_busy |-> !i_point.ready)
        else $error("item accepted while cosine and sine were being updated");

endmodule

// File: hw/rtl/rvaa_trig.sv
// Cosine and sine sequencer: works out the held Q1.16 values from the angle.
// Depends on rvaa_pkg.
module rvaa_trig (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [15:0]     i_angle,
    output logic            o_busy,
    output rvaa_pkg::t_trig o_trig
);

    rvaa_pkg::t_trig_state r_state, n_state;
    logic [14:0]           r_m, n_m;
    rvaa_pkg::t_quadrant   r_quad, n_quad;
    logic                  r_swap, n_swap;
    logic [11:0]           r_rr, n_rr;
    logic [29:0]           r_x, n_x;
    logic [29:0]           r_x2, n_x2;
    logic [30:0]           r_t, n_t;
    logic [29:0]           r_num, n_num;
    logic [29:0]           r_quo, n_quo;
    logic [3:0]            r_step, n_step;
    logic [16:0]           r_sin_oct, n_sin_oct;
    logic [16:0]           r_cos_oct, n_cos_oct;
    rvaa_pkg::t_trig       r_trig, n_trig;

    logic signed [17:0] angle_s;
    logic [14:0]        m_wrap;
    logic [12:0]        fold_r;
    logic [33:0]        rad_prod;
    logic [29:0]        mul_a;
    logic [31:0]        mul_b;
    logic [61:0]        mul_p;
    logic [30:0]        prod_q30;
    logic [6:0]         div_k;
    logic [31:0]        div_m;
    logic [29:0]        fix_prod;
    logic [29:0]        fix_rem;
    logic signed [17:0] oct_s;
    logic signed [17:0] oct_c;

    // Wrap the signed angle into one turn.
    assign angle_s = 18'(signed'(i_angle));
    always_comb begin
        priority if (angle_s < -18'sd23040) begin
            m_wrap = 15'(angle_s + 18'(2 * rvaa_pkg::STEPS_FULL));
        end else if (angle_s < 18'sd0) begin
            m_wrap = 15'(angle_s + 18'(rvaa_pkg::STEPS_FULL));
        end else if (angle_s >= 18'(rvaa_pkg::STEPS_FULL)) begin
            m_wrap = 15'(angle_s - 18'(rvaa_pkg::STEPS_FULL));
        end else begin
            m_wrap = 15'(angle_s);
        end
    end

    // One multiplier serves the square, the Horner products, the reciprocal
    // divide and the final sine scale.
    assign mul_a    = (r_state == rvaa_pkg::TRIG_MUL) ? r_x2 :
                      (r_state == rvaa_pkg::TRIG_DIV) ? r_num : r_x;
    assign mul_b    = (r_state == rvaa_pkg::TRIG_SQR) ? {2'b00, r_x} :
                      (r_state == rvaa_pkg::TRIG_DIV) ? div_m : {1'b0, r_t};
    assign mul_p    = 62'(mul_a) * 62'(mul_b);
    assign prod_q30 = 31'(mul_p >> 30);
    assign rad_prod = 34'(r_rr) * 34'(rvaa_pkg::RAD_PER_STEP) + 34'd2;

    // The reciprocal quotient is low by at most one; the remainder tells.
    assign div_k    = rvaa_pkg::horner_div(r_step);
    assign div_m    = rvaa_pkg::horner_recip(r_step);
    assign fix_prod = r_quo * 30'(div_k);
    assign fix_rem  = r_num - fix_prod;
    assign oct_s = 18'(r_swap ? r_cos_oct : r_sin_oct);
    assign oct_c = 18'(r_swap ? r_sin_oct : r_cos_oct);

    always_comb begin
        n_state   = r_state;
        n_m       = r_m;
        n_quad    = r_quad;
        n_swap    = r_swap;
        n_rr      = r_rr;
        n_x       = r_x;
        n_x2      = r_x2;
        n_t       = r_t;
        n_num     = r_num;
        n_quo     = r_quo;
        n_step    = r_step;
        n_sin_oct = r_sin_oct;
        n_cos_oct = r_cos_oct;
        n_trig    = r_trig;
        fold_r    = 13'(r_m);
        unique case (r_state)
            rvaa_pkg::TRIG_IDLE: begin
            end
            rvaa_pkg::TRIG_FOLD: begin
                priority if (r_m < 15'(rvaa_pkg::STEPS_QUAD)) begin
                    n_quad = rvaa_pkg::QUAD_0;
                    fold_r = 13'(r_m);
                end else if (r_m < 15'(2 * rvaa_pkg::STEPS_QUAD)) begin
                    n_quad = rvaa_pkg::QUAD_1;
                    fold_r = 13'(r_m - 15'(rvaa_pkg::STEPS_QUAD));
                end else if (r_m < 15'(3 * rvaa_pkg::STEPS_QUAD)) begin
                    n_quad = rvaa_pkg::QUAD_2;
                    fold_r = 13'(r_m - 15'(2 * rvaa_pkg::STEPS_QUAD));
                end else begin
                    n_quad = rvaa_pkg::QUAD_3;
                    fold_r = 13'(r_m - 15'(3 * rvaa_pkg::STEPS_QUAD));
                end
                // Past the octant, sine and cosine of the complement swap roles.
                if (fold_r <= 13'(rvaa_pkg::STEPS_OCT)) begin
                    n_rr   = 12'(fold_r);
                    n_swap = 1'b0;
                end else begin
                    n_rr   = 12'(13'(rvaa_pkg::STEPS_QUAD) - fold_r);
                    n_swap = 1'b1;
                end
                n_step  = '0;
                n_t     = 31'(rvaa_pkg::ONE_Q30);
                n_state = rvaa_pkg::TRIG_RAD;
            end
            rvaa_pkg::TRIG_RAD: begin
                n_x     = 30'(rad_prod >> 2);
                n_state = rvaa_pkg::TRIG_SQR;
            end
            rvaa_pkg::TRIG_SQR: begin
                n_x2    = 30'(prod_q30);
                n_state = rvaa_pkg::TRIG_MUL;
            end
            rvaa_pkg::TRIG_MUL: begin
                n_num   = 30'(prod_q30);
                n_state = rvaa_pkg::TRIG_DIV;
            end
            rvaa_pkg::TRIG_DIV: begin
                n_quo   = 30'(mul_p >> 32);
                n_state = rvaa_pkg::TRIG_FIX;
            end
            rvaa_pkg::TRIG_FIX: begin
                if (fix_rem >= 30'(div_k)) begin
                    n_quo = r_quo + 30'd1;
                end
                n_state = rvaa_pkg::TRIG_SUB;
            end
            rvaa_pkg::TRIG_SUB: begin
                n_t = 31'(rvaa_pkg::ONE_Q30) - {1'b0, r_quo};
                priority if (r_step == 4'(rvaa_pkg::SIN_LAST)) begin
                    n_step  = r_step + 4'd1;
                    n_state = rvaa_pkg::TRIG_SINF;
                end else if (r_step == 4'(rvaa_pkg::COS_LAST)) begin
                    n_cos_oct = 17'((n_t + 31'(rvaa_pkg::HALF_Q14)) >> 14);
                    n_state   = rvaa_pkg::TRIG_DONE;
                end else begin
                    n_step  = r_step + 4'd1;
                    n_state = rvaa_pkg::TRIG_MUL;
                end
            end
            rvaa_pkg::TRIG_SINF: begin
                n_sin_oct = 17'((prod_q30 + 31'(rvaa_pkg::HALF_Q14)) >> 14);
                n_t       = 31'(rvaa_pkg::ONE_Q30);
                n_state   = rvaa_pkg::TRIG_MUL;
            end
            rvaa_pkg::TRIG_DONE: begin
                unique case (r_quad)
                    rvaa_pkg::QUAD_0: begin
                        n_trig.cosine = oct_c;
                        n_trig.sine   = oct_s;
                    end
                    rvaa_pkg::QUAD_1: begin
                        n_trig.cosine = -oct_s;
                        n_trig.sine   = oct_c;
                    end
                    rvaa_pkg::QUAD_2: begin
                        n_trig.cosine = -oct_c;
                        n_trig.sine   = -oct_s;
                    end
                    rvaa_pkg::QUAD_3: begin
                        n_trig.cosine = oct_s;
                        n_trig.sine   = -oct_c;
                    end
                endcase
                n_state = rvaa_pkg::TRIG_IDLE;
            end
            default: begin
                n_state = rvaa_pkg::TRIG_IDLE;
            end
        endcase
        // A new angle restarts the sequence from the top.
        if (i_start) begin
            n_m     = m_wrap;
            n_state = rvaa_pkg::TRIG_FOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rvaa_pkg::TRIG_IDLE;
            r_trig  <= rvaa_pkg::TRIG_RESET;
        end else begin
            r_state <= n_state;
            r_trig  <= n_trig;
        end
        r_m       <= n_m;
        r_quad    <= n_quad;
        r_swap    <= n_swap;
        r_rr      <= n_rr;
        r_x       <= n_x;
        r_x2      <= n_x2;
        r_t       <= n_t;
        r_num     <= n_num;
        r_quo     <= n_quo;
        r_step    <= n_step;
        r_sin_oct <= n_sin_oct;
        r_cos_oct <= n_cos_oct;
    end

    assign o_busy = (r_state != rvaa_pkg::TRIG_IDLE);
    assign o_trig = r_trig;

    a_start_folds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_state == rvaa_pkg::TRIG_FOLD)
        else $error("angle write did not restart the sequencer");

    a_div_fixes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rvaa_pkg::TRIG_DIV && !i_start
        |=> r_state == rvaa_pkg::TRIG_FIX)
        else $error("division did not move on to its correction step");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rvaa_pkg::TRIG_DONE && !i_start |=> !o_busy)
        else $error("sequencer stayed busy after storing the result");

endmodule

// File: hw/rtl/rvaa_core.sv
// Seven-stage point pipeline: dot and cross products, parallel part, scaling and saturation.
// Depends on rvaa_pkg, rvaa_point_if and rvaa_rotated_if.
module rvaa_core #(
    parameter int COORD_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_hold,
    input  rvaa_pkg::t_axis i_axis,
    input  rvaa_pkg::t_trig i_trig,
    rvaa_point_if.sink      i_point,
    rvaa_rotated_if.source  o_rotated
);

    localparam int W    = COORD_WIDTH;
    localparam int AW   = rvaa_pkg::AXIS_W;
    localparam int TW   = rvaa_pkg::TRIG_W;
    localparam int PW   = W + AW;        // point times axis
    localparam int DSW  = W + AW + 2;    // sum of three products
    localparam int DW   = W + 4;         // rounded dot product
    localparam int CSW  = W + AW + 1;    // difference of two products
    localparam int CW   = W + 3;         // rounded cross product
    localparam int PRW  = DW + AW;       // dot times axis
    localparam int PARW = W + 6;         // parallel part
    localparam int PERW = W + 7;         // perpendicular part
    localparam int MCW  = PERW + TW;
    localparam int MSW  = CW + TW;
    localparam int SUMW = MCW + 1;
    localparam int RSW  = W + 10;
    localparam int FW   = W + 11;
    localparam int NSTG = 7;

    localparam logic signed [DSW-1:0]  HALF_DS  = DSW'(8192);
    localparam logic signed [CSW-1:0]  HALF_CS  = CSW'(8192);
    localparam logic signed [PRW-1:0]  HALF_PR  = PRW'(8192);
    localparam logic signed [SUMW-1:0] HALF_SUM = SUMW'(32768);
    localparam logic signed [FW-1:0]   SAT_MAX  = FW'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [FW-1:0]   SAT_MIN  = -SAT_MAX - FW'(1);

    logic [NSTG:1] r_v;
    logic [NSTG:1] en;
    logic          take;

    logic signed [W-1:0]  in_p [3];
    logic signed [AW-1:0] ax [3];

    logic signed [W-1:0]    r1_p [3];
    logic signed [PW-1:0]   r1_dot [3];
    logic signed [PW-1:0]   r1_cra [3];
    logic signed [PW-1:0]   r1_crb [3];
    logic signed [DSW-1:0]  n2_dsum;
    logic signed [CSW-1:0]  n2_cd [3];
    logic signed [W-1:0]    r2_p [3];
    logic signed [DW-1:0]   r2_dot;
    logic signed [CW-1:0]   r2_cr [3];
    logic signed [W-1:0]    r3_p [3];
    logic signed [PRW-1:0]  r3_pr [3];
    logic signed [CW-1:0]   r3_cr [3];
    logic signed [PRW-1:0]  n4_rp [3];
    logic signed [PARW-1:0] n4_par [3];
    logic signed [PARW-1:0] r4_par [3];
    logic signed [PERW-1:0] r4_perp [3];
    logic signed [CW-1:0]   r4_cr [3];
    logic signed [MCW-1:0]  r5_mc [3];
    logic signed [MSW-1:0]  r5_ms [3];
    logic signed [PARW-1:0] r5_par [3];
    logic signed [SUMW-1:0] n6_sum [3];
    logic signed [RSW-1:0]  r6_rs [3];
    logic signed [PARW-1:0] r6_par [3];
    logic signed [FW-1:0]   n7_f [3];
    logic signed [FW-1:0]   n7_sat [3];
    logic signed [W-1:0]    r7_rot [3];

    assign in_p[0] = i_point.point_x;
    assign in_p[1] = i_point.point_y;
    assign in_p[2] = i_point.point_z;
    assign ax[0]   = i_axis.x;
    assign ax[1]   = i_axis.y;
    assign ax[2]   = i_axis.z;

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        en[NSTG] = !r_v[NSTG] || o_rotated.ready;
        for (int i = NSTG - 1; i >= 1; i--) begin
            en[i] = !r_v[i] || en[i+1];
        end
    end

    assign i_point.ready = en[1] && !i_hold;
    assign take          = i_point.valid && i_point.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= take;
            end
            for (int i = 2; i <= NSTG; i++) begin
                if (en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // Stage 1: all nine point-by-axis products.
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int k = 0; k < 3; k++) begin
                r1_p[k]   <= in_p[k];
                r1_dot[k] <= PW'(in_p[k]) * PW'(ax[k]);
            end
            r1_cra[0] <= PW'(in_p[2]) * PW'(ax[1]);
            r1_crb[0] <= PW'(in_p[1]) * PW'(ax[2]);
            r1_cra[1] <= PW'(in_p[0]) * PW'(ax[2]);
            r1_crb[1] <= PW'(in_p[2]) * PW'(ax[0]);
            r1_cra[2] <= PW'(in_p[1]) * PW'(ax[0]);
            r1_crb[2] <= PW'(in_p[0]) * PW'(ax[1]);
        end
    end

    // Stage 2: dot product and cross product, rounded to Q16.16.
    always_comb begin
        n2_dsum = DSW'(r1_dot[0]) + DSW'(r1_dot[1]) + DSW'(r1_dot[2]) + HALF_DS;
        for (int k = 0; k < 3; k++) begin
            n2_cd[k] = CSW'(r1_cra[k]) - CSW'(r1_crb[k]) + HALF_CS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_dot <= DW'(n2_dsum >>> 14);
            for (int k = 0; k < 3; k++) begin
                r2_p[k]  <= r1_p[k];
                r2_cr[k] <= CW'(n2_cd[k] >>> 14);
            end
        end
    end

    // Stage 3: dot product scaled by each axis component.
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            for (int k = 0; k < 3; k++) begin
                r3_pr[k] <= PRW'(r2_dot) * PRW'(ax[k]);
                r3_p[k]  <= r2_p[k];
                r3_cr[k] <= r2_cr[k];
            end
        end
    end

    // Stage 4: parallel part and the perpendicular remainder.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n4_rp[k]  = r3_pr[k] + HALF_PR;
            n4_par[k] = PARW'(n4_rp[k] >>> 14);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            for (int k = 0; k < 3; k++) begin
                r4_par[k]  <= n4_par[k];
                r4_perp[k] <= PERW'(r3_p[k]) - PERW'(n4_par[k]);
                r4_cr[k]   <= r3_cr[k];
            end
        end
    end

    // Stage 5: scale by the held cosine and sine.
    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            for (int k = 0; k < 3; k++) begin
                r5_mc[k]  <= MCW'(r4_perp[k]) * MCW'(i_trig.cosine);
                r5_ms[k]  <= MSW'(r4_cr[k]) * MSW'(i_trig.sine);
                r5_par[k] <= r4_par[k];
            end
        end
    end

    // Stage 6: sum and round from Q.32 to Q16.16.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n6_sum[k] = SUMW'(r5_mc[k]) + SUMW'(r5_ms[k]) + HALF_SUM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            for (int k = 0; k < 3; k++) begin
                r6_rs[k]  <= RSW'(n6_sum[k] >>> 16);
                r6_par[k] <= r5_par[k];
            end
        end
    end

    // Stage 7: add the parallel part back and saturate into the output register.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n7_f[k] = FW'(r6_rs[k]) + FW'(r6_par[k]);
            if (n7_f[k] > SAT_MAX) begin
                n7_sat[k] = SAT_MAX;
            end else if (n7_f[k] < SAT_MIN) begin
                n7_sat[k] = SAT_MIN;
            end else begin
                n7_sat[k] = n7_f[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NSTG]) begin
            for (int k = 0; k < 3; k++) begin
                r7_rot[k] <= W'(n7_sat[k]);
            end
        end
    end

    assign o_rotated.valid     = r_v[NSTG];
    assign o_rotated.rotated_x = r7_rot[0];
    assign o_rotated.rotated_y = r7_rot[1];
    assign o_rotated.rotated_z = r7_rot[2];

    a_take_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_v[1])
        else $error("accepted item did not reach the first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NSTG-1] && !en[NSTG] |=> r_v[NSTG-1])
        else $error("item lost in a stalled stage");

    a_moves_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NSTG-1] && en[NSTG] |=> r_v[NSTG])
        else $error("item did not move into the output register");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for rotate_vector_about_axis_unit (Rodrigues point rotation).
// Depends on rvaa_pkg, rvaa_point_if, rvaa_rotated_if and the block itself.
module testbench;

    localparam int COORD_W = 32;
    localparam int CLK_HALF = 10;
    // Cycles with work outstanding but no handshake before the run is declared hung.
    // The longest legitimate quiet stretch is a receiver hold-off overlapping
    // the sine/cosine sequencer after an angle write.
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 250;
    localparam int HOLD_EVERY = 900;
    localparam int RANDOM_PHASES = 19;
    localparam int POINTS_PER_PHASE = 100;
    localparam longint SAT_HI = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_vec3;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [rvaa_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [rvaa_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    rvaa_point_if   #(.COORD_WIDTH(COORD_W)) point_ch ();
    rvaa_rotated_if #(.COORD_WIDTH(COORD_W)) rot_ch ();

    rotate_vector_about_axis_unit #(.COORD_WIDTH(COORD_W)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_point     (point_ch),
        .o_rotated   (rot_ch)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Shadow copy of the configuration and of the held cosine and sine (Q1.16).
    logic signed [rvaa_pkg::AXIS_W-1:0] axis_x_reg;
    logic signed [rvaa_pkg::AXIS_W-1:0] axis_y_reg;
    logic signed [rvaa_pkg::AXIS_W-1:0] axis_z_reg;
    logic signed [15:0]                 angle_reg;
    int                                 cosine_q16;
    int                                 sine_q16;

    t_vec3 pending_points[$];
    t_vec3 expected_rotations[$];

    // Idle behavior of both sides; changed only between phases.
    int gap_max;
    int stall_pct;

    int points_accepted;
    int rotations_checked;
    int saturated_coords;
    int settings_loaded;
    int holds_applied;
    int mismatch_count;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Round half up and shift right arithmetically, so ties go toward +infinity.
    function automatic longint round_shift(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    // One Horner step of the Taylor series, all values non-negative Q30.
    function automatic longint unsigned horner_term(longint unsigned x2, longint unsigned t,
                                                    longint unsigned k);
        return 64'(rvaa_pkg::ONE_Q30) - ((x2 * t) >> 30) / k;
    endfunction

    function automatic int q30_to_q16(longint unsigned v);
        return int'((v + 64'd8192) >> 14);
    endfunction

    // Remainder in angle steps, 0 to 45 degrees, as radians in Q30.
    function automatic longint unsigned octant_radians(int unsigned r);
        return (64'(r) * 64'(rvaa_pkg::RAD_PER_STEP) + 64'd2) >> 2;
    endfunction

    function automatic int sine_octant(int unsigned r);
        longint unsigned x, x2, t;
        x = octant_radians(r);
        x2 = (x * x) >> 30;
        t = 64'(rvaa_pkg::ONE_Q30) - x2 / 72;
        t = horner_term(x2, t, 42);
        t = horner_term(x2, t, 20);
        t = horner_term(x2, t, 6);
        return q30_to_q16((x * t) >> 30);
    endfunction

    function automatic int cosine_octant(int unsigned r);
        longint unsigned x, x2, t;
        x = octant_radians(r);
        x2 = (x * x) >> 30;
        t = 64'(rvaa_pkg::ONE_Q30) - x2 / 90;
        t = horner_term(x2, t, 56);
        t = horner_term(x2, t, 30);
        t = horner_term(x2, t, 12);
        t = horner_term(x2, t, 2);
        return q30_to_q16(t);
    endfunction

    // Recompute the held cosine and sine from the angle register. The angle is
    // wrapped to one turn, split into a quadrant and a remainder, and the
    // remainder is folded about 45 degrees so the series only see small angles.
    function automatic void refresh_trig();
        int          m;
        int unsigned r;
        int          s;
        int          c;
        logic [1:0]  quad;
        m = int'(angle_reg) % rvaa_pkg::STEPS_FULL;
        if (m < 0) begin
            m += rvaa_pkg::STEPS_FULL;
        end
        quad = 2'(m / rvaa_pkg::STEPS_QUAD);
        r = m % rvaa_pkg::STEPS_QUAD;
        if (r <= rvaa_pkg::STEPS_OCT) begin
            s = sine_octant(r);
            c = cosine_octant(r);
        end else begin
            s = cosine_octant(rvaa_pkg::STEPS_QUAD - r);
            c = sine_octant(rvaa_pkg::STEPS_QUAD - r);
        end
        case (rvaa_pkg::t_quadrant'(quad))
            rvaa_pkg::QUAD_0: begin
                sine_q16 = s;
                cosine_q16 = c;
            end
            rvaa_pkg::QUAD_1: begin
                sine_q16 = c;
                cosine_q16 = -s;
            end
            rvaa_pkg::QUAD_2: begin
                sine_q16 = -s;
                cosine_q16 = -c;
            end
            default: begin
                sine_q16 = -c;
                cosine_q16 = s;
            end
        endcase
    endfunction

    // v' = (v - a(a.v)) cos + (a x v) sin + a(a.v), rounded at each stage as the
    // block does, then saturated per coordinate. Every intermediate stays well
    // inside 64 bits even for a non-unit axis at its extremes.
    function automatic t_vec3 rotate_point(t_vec3 p);
        longint pv[3];
        longint av[3];
        longint cr[3];
        longint dot;
        longint par;
        longint sum;
        t_vec3  r;
        pv[0] = p.x;
        pv[1] = p.y;
        pv[2] = p.z;
        av[0] = axis_x_reg;
        av[1] = axis_y_reg;
        av[2] = axis_z_reg;
        dot = round_shift(pv[0] * av[0] + pv[1] * av[1] + pv[2] * av[2], 14);
        cr[0] = round_shift(pv[2] * av[1] - pv[1] * av[2], 14);
        cr[1] = round_shift(pv[0] * av[2] - pv[2] * av[0], 14);
        cr[2] = round_shift(pv[1] * av[0] - pv[0] * av[1], 14);
        for (int k = 0; k < 3; k++) begin
            par = round_shift(dot * av[k], 14);
            sum = round_shift((pv[k] - par) * longint'(cosine_q16)
                              + cr[k] * longint'(sine_q16), 16) + par;
            if (sum > SAT_HI) begin
                sum = SAT_HI;
                saturated_coords++;
            end else if (sum < SAT_LO) begin
                sum = SAT_LO;
                saturated_coords++;
            end
            case (k)
                0: r.x = sum[COORD_W-1:0];
                1: r.y = sum[COORD_W-1:0];
                default: r.z = sum[COORD_W-1:0];
            endcase
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps. An item is
    // predicted at the edge where it is accepted, so the expectation always
    // uses the configuration the block sees.
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            point_ch.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (point_ch.valid && point_ch.ready) begin
                expected_rotations.push_back(rotate_point(
                    t_vec3'{x: point_ch.point_x, y: point_ch.point_y, z: point_ch.point_z}));
                points_accepted++;
            end
            // A new item may only be put up once the current one is gone.
            if (!point_ch.valid || point_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    point_ch.valid <= 1'b0;
                end else if (pending_points.size() != 0) begin
                    t_vec3 nxt;
                    nxt = pending_points.pop_front();
                    point_ch.point_x <= nxt.x;
                    point_ch.point_y <= nxt.y;
                    point_ch.point_z <= nxt.z;
                    point_ch.valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(24, 1);
                        gap_left <= (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    point_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: runs of ready and stall whose mix follows stall_pct. After 400
    // accepted items, then every HOLD_EVERY more, it also holds off for a long stretch
    // while the sender offers, which fills the pipeline and must stall the input.
    // ------------------------------------------------------------------
    int run_left;
    int hold_left;
    int next_hold_at;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rot_ch.ready <= 1'b0;
            run_left <= 0;
            hold_left <= 0;
            next_hold_at <= 400;
        end else if (hold_left != 0) begin
            rot_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (points_accepted >= next_hold_at) begin
            rot_ch.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + HOLD_EVERY;
            holds_applied++;
        end else if (run_left != 0) begin
            run_left <= run_left - 1;
        end else begin
            rot_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
            run_left <= $urandom_range(7, 0);
        end
    end

    // ------------------------------------------------------------------
    // Checker: each accepted result against the oldest expectation.
    // ------------------------------------------------------------------
    function automatic void check_coord(string name, logic signed [COORD_W-1:0] want,
                                        logic signed [COORD_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && rot_ch.valid && rot_ch.ready) begin
            if (expected_rotations.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with nothing expected, got (%0d, %0d, %0d)", $time,
                         rot_ch.rotated_x, rot_ch.rotated_y, rot_ch.rotated_z);
            end else begin
                t_vec3 want;
                want = expected_rotations.pop_front();
                check_coord("rotated_x", want.x, rot_ch.rotated_x);
                check_coord("rotated_y", want.y, rot_ch.rotated_y);
                check_coord("rotated_z", want.z, rot_ch.rotated_z);
                rotations_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: only counts while work is outstanding, so phase changes and
    // the final drain do not trip it.
    // ------------------------------------------------------------------
    int quiet_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((point_ch.valid && point_ch.ready) || (rot_ch.valid && rot_ch.ready)
                     || (pending_points.size() == 0 && !point_ch.valid
                         && expected_rotations.size() == 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                     quiet_cycles, expected_rotations.size());
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Wait until every item has been sent and every result has come back.
    task automatic wait_drained();
        while (pending_points.size() != 0 || point_ch.valid
               || expected_rotations.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_register(rvaa_pkg::t_cfg_index idx,
                                  logic [rvaa_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        case (idx)
            rvaa_pkg::CFG_AXIS_X: axis_x_reg = value;
            rvaa_pkg::CFG_AXIS_Y: axis_y_reg = value;
            rvaa_pkg::CFG_AXIS_Z: axis_z_reg = value;
            default: begin
                angle_reg = value;
                refresh_trig();
            end
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Registers change only with the block idle. The angle goes last; its write
    // keeps the input stalled while the sequencer runs, which the sender rides out.
    task automatic load_setting(int ax, int ay, int az, int angle);
        wait_drained();
        write_register(rvaa_pkg::CFG_AXIS_X, 16'(ax));
        write_register(rvaa_pkg::CFG_AXIS_Y, 16'(ay));
        write_register(rvaa_pkg::CFG_AXIS_Z, 16'(az));
        write_register(rvaa_pkg::CFG_TURN_ANGLE, 16'(angle));
        settings_loaded++;
        @(negedge i_clk);
    endtask

    task automatic queue_point(int x, int y, int z);
        pending_points.push_back(t_vec3'{x: x, y: y, z: z});
    endtask

    // Mostly moderate coordinates of random magnitude, some full-range values
    // and some exact extremes.
    function automatic int random_coord();
        int pick;
        int v;
        pick = $urandom_range(99, 0);
        if (pick < 15) begin
            case ($urandom_range(6, 0))
                0: v = 0;
                1: v = 1;
                2: v = -1;
                3: v = 32'h7FFFFFFF;
                4: v = 32'h80000000;
                5: v = 65536;
                default: v = -65536;
            endcase
        end else begin
            v = $urandom;
            if (pick < 75) begin
                v = v >>> $urandom_range(16, 4);
            end
        end
        return v;
    endfunction

    int unit_axes[8][3] = '{
        '{16384, 0, 0}, '{0, 16384, 0}, '{0, 0, 16384}, '{-16384, 0, 0},
        '{0, 0, -16384}, '{9459, 9459, 9459}, '{11585, 11585, 0}, '{0, -11585, 11585}
    };
    // Quadrant and octant boundaries, full-turn wraps and the register extremes.
    int angle_marks[14] = '{
        0, 1440, 2880, 2881, 5760, 8640, 11520, 17280, 23039, 23040, -1, -23040,
        -32768, 32767
    };

    initial begin
        int ax;
        int ay;
        int az;
        int angle;
        int pick;
        int extremes[3];

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = rvaa_pkg::CFG_AXIS_X;
        i_cfg_data = '0;
        point_ch.valid = 1'b0;
        point_ch.point_x = '0;
        point_ch.point_y = '0;
        point_ch.point_z = '0;
        rot_ch.ready = 1'b0;
        gap_max = 0;
        stall_pct = 0;
        points_accepted = 0;
        rotations_checked = 0;
        saturated_coords = 0;
        settings_loaded = 0;
        holds_applied = 0;
        mismatch_count = 0;
        extremes = '{-32768, 32767, 0};

        // After reset the axis is +z and the angle zero, so points pass unchanged.
        axis_x_reg = 0;
        axis_y_reg = 0;
        axis_z_reg = 16384;
        angle_reg = 0;
        refresh_trig();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, first on the reset configuration.
        queue_point(0, 0, 0);
        queue_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        queue_point(32'h80000000, 32'h80000000, 32'h80000000);
        queue_point(1, -1, 65536);
        queue_point(32'h80000000, 32'h7FFFFFFF, 0);

        // Quarter turn about +x: x stays put, y turns onto z and z onto -y.
        load_setting(16384, 0, 0, 5760);
        queue_point(65536, 0, 0);
        queue_point(0, 65536, 0);
        queue_point(0, 0, 65536);
        queue_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        queue_point(-1, 1, -1);

        // Diagonal axis, angle one step past 45 degrees so the octant fold is used.
        load_setting(9459, 9459, 9459, 2881);
        queue_point(65536, 0, 0);
        queue_point(-123456, 7654321, -98765);
        queue_point(32'h7FFFFFFF, 0, 32'h80000000);

        // Non-unit axis at the negative extreme with the most negative angle:
        // the result is scaled up and must saturate.
        load_setting(-32768, -32768, -32768, -32768);
        queue_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        queue_point(32'h80000000, 0, 32'h7FFFFFFF);
        queue_point(32'h12345678, -32'h12345678, 32'h0ABCDEF0);
        queue_point(65536, 65536, 65536);

        // Positive axis extremes with the largest angle register value.
        load_setting(32767, 32767, 32767, 32767);
        queue_point(32'h80000000, 32'h80000000, 32'h80000000);
        queue_point(32'h7FFFFFFF, 32'h80000001, 1);
        queue_point(3 << 16, -(5 << 16), 7 << 16);

        // Half turn about -z.
        load_setting(0, 0, -16384, 11520);
        queue_point(65536, 65536, 65536);
        queue_point(-1, 0, 32'h7FFFFFFF);

        // Random part: each phase picks an axis, an angle and idle behavior.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            pick = $urandom_range(9, 0);
            if (pick < 5) begin
                pick = $urandom_range(7, 0);
                ax = unit_axes[pick][0];
                ay = unit_axes[pick][1];
                az = unit_axes[pick][2];
            end else if (pick < 8) begin
                ax = $signed(16'($urandom));
                ay = $signed(16'($urandom));
                az = $signed(16'($urandom));
            end else begin
                ax = extremes[$urandom_range(2, 0)];
                ay = extremes[$urandom_range(2, 0)];
                az = extremes[$urandom_range(2, 0)];
            end
            if ($urandom_range(1, 0) == 0) begin
                angle = angle_marks[$urandom_range(13, 0)];
            end else begin
                angle = $signed(16'($urandom));
            end
            load_setting(ax, ay, az, angle);

            // The first phase runs with no idling at all on either side.
            if (ph == 0) begin
                gap_max = 0;
                stall_pct = 0;
            end else begin
                case ($urandom_range(2, 0))
                    0: gap_max = 0;
                    1: gap_max = 3;
                    default: gap_max = 12;
                endcase
                case ($urandom_range(3, 0))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 80;
                endcase
            end

            for (int n = 0; n < POINTS_PER_PHASE; n++) begin
                queue_point(random_coord(), random_coord(), random_coord());
            end
        end

        // Drain, then give the pipeline time to show any stray result.
        wait_drained();
        repeat (12) @(posedge i_clk);

        $display("Rotated and checked %0d points under %0d register settings.",
                 rotations_checked, settings_loaded);
        $display("%0d coordinates saturated; %0d long receiver hold-offs applied.",
                 saturated_coords, holds_applied);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/rvaa_pkg.sv
hw/rtl/rvaa_point_if.sv
hw/rtl/rvaa_rotated_if.sv
hw/rtl/rvaa_trig.sv
hw/rtl/rvaa_core.sv
hw/rtl/rotate_vector_about_axis_unit.sv
verif/testbench.sv
